// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks that are disabled during reset.
// The including module must have clk_i and rst_ni in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PDEB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pdeb: assertion failed");

// Next-cycle implication.
`define PDEB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pdeb: assertion failed");

`endif

// ===== design/pdeb_pkg.sv =====
// ---------------------------------------------------------------------------
// pdeb_pkg
// Shared types, constants and helpers of the per-domain error budget block.
// ---------------------------------------------------------------------------
package pdeb_pkg;

  localparam int unsigned DEF_DOMAIN_COUNT = 8;
  localparam int unsigned CNT_W            = 32;
  localparam int unsigned DOM_W            = 5;
  localparam int unsigned MASK_W           = 8;
  localparam int unsigned ACT_W            = 2;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned STEP_W           = $clog2(CNT_W);

  localparam logic [CNT_W-1:0] SAT_MAX         = '1;
  localparam logic [CNT_W-1:0] RST_FAULT_THR   = CNT_W'(8);
  localparam logic [CNT_W-1:0] RST_REINIT_INT  = CNT_W'(3);
  localparam logic [CNT_W-1:0] RST_RECOVER_OK  = CNT_W'(16);
  localparam logic [STEP_W-1:0] STEP_LAST      = STEP_W'(CNT_W - 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE   = 2'd0,
    ACT_REINIT = 2'd1,
    ACT_FAULT  = 2'd2
  } pdeb_action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAULT_THR  = 2'd0,
    REG_REINIT_INT = 2'd1,
    REG_RECOVER_OK = 2'd2
  } pdeb_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EVAL,
    ST_DIV,
    ST_WRITE
  } pdeb_state_e;

  typedef struct packed {
    logic [CNT_W-1:0] fail_total;
    logic [CNT_W-1:0] fail_streak;
    logic [CNT_W-1:0] succ_run;
    logic [CNT_W-1:0] reinit_total;
  } pdeb_entry_t;

  typedef struct packed {
    logic en;
    logic flag_set;
    logic flag_clr;
  } pdeb_wr_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == SAT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== design/pdeb_if.sv =====
// ---------------------------------------------------------------------------
// pdeb_if
// Valid/ready channels carrying outcome reports in and budget results out.
// ---------------------------------------------------------------------------
interface pdeb_in_if import pdeb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [DOM_W-1:0] domain;

  modport source (output valid, output operation, output domain, input ready);
  modport sink   (input valid, input operation, input domain, output ready);
endinterface

interface pdeb_out_if import pdeb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic              domain_faulted;
  logic [MASK_W-1:0] fault_mask;
  logic [CNT_W-1:0]  total_failures;
  logic [CNT_W-1:0]  streak_failures;
  logic [CNT_W-1:0]  reinit_count;

  modport source (output valid, output action, output domain_faulted, output fault_mask,
                  output total_failures, output streak_failures, output reinit_count,
                  input ready);
  modport sink   (input valid, input action, input domain_faulted, input fault_mask,
                  input total_failures, input streak_failures, input reinit_count,
                  output ready);
endinterface

// ===== design/per_domain_error_budget_core.sv =====
// ---------------------------------------------------------------------------
// per_domain_error_budget_core
// Tracks per-domain transaction failures and advises re-init or fault.
// An outcome beat (operation, domain) enters on in_i; exactly one result beat
// leaves on out_o for each one. Config registers are written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write them only while the
// block is idle, which the block itself does not enforce. A failure on a
// valid domain that neither latches a fault nor has a zero interval runs a
// 32-step serial remainder of the streak by reinit_interval and passes the
// load, eval, div and write states; other items on a valid domain pass
// load, eval and write, and an ignored domain passes load and write.
// One item is in work at a time, and the next beat can be taken in the
// idle state in the cycle after the result is loaded.
// The result sits in an output register, so a new beat is taken while it
// waits; a stalled receiver holds the next result in the write state.
// Reset clears all counters and fault flags and loads the register defaults.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module per_domain_error_budget_core import pdeb_pkg::*; #(
  parameter int unsigned DOMAIN_COUNT = DEF_DOMAIN_COUNT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CNT_W-1:0]     cfg_wdata_i,
  pdeb_in_if.sink              in_i,
  pdeb_out_if.source           out_o
);

  localparam int unsigned IDX_W = (DOMAIN_COUNT > 1) ? $clog2(DOMAIN_COUNT) : 1;

  pdeb_state_e state_q, state_d;

  logic [CNT_W-1:0] thr_q, rint_q, rec_q;

  logic             op_q;
  logic [DOM_W-1:0] dom_q;
  logic             dom_ok_q;
  logic [IDX_W-1:0] idx;

  pdeb_entry_t  wk_q, wk_d;
  pdeb_action_e act_q, act_d;
  logic         clr_q, clr_d;

  pdeb_entry_t             tbl_entry;
  pdeb_wr_t                tbl_wr;
  logic [DOMAIN_COUNT-1:0] tbl_flags;
  logic [DOMAIN_COUNT-1:0] flags_new;
  logic [DOMAIN_COUNT+MASK_W-1:0] flags_ext;

  logic             div_start;
  logic             div_done;
  logic [CNT_W-1:0] div_rem;

  logic              out_load;
  logic              out_valid_q;
  logic [ACT_W-1:0]  out_act_q;
  logic              out_flt_q;
  logic [MASK_W-1:0] out_mask_q;
  logic [CNT_W-1:0]  out_tot_q, out_str_q, out_rei_q;

  logic in_beat;

  assign idx     = dom_q[IDX_W-1:0];
  assign in_beat = in_i.valid && in_i.ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= RST_FAULT_THR;
      rint_q <= RST_REINIT_INT;
      rec_q  <= RST_RECOVER_OK;
    end else if (cfg_we_i) begin
      case (pdeb_reg_e'(cfg_idx_i))
        REG_FAULT_THR:  thr_q  <= cfg_wdata_i;
        REG_REINIT_INT: rint_q <= cfg_wdata_i;
        REG_RECOVER_OK: rec_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pdeb_table #(
    .DOMAIN_COUNT (DOMAIN_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .idx_i   (idx),
    .wr_i    (tbl_wr),
    .entry_i (wk_q),
    .entry_o (tbl_entry),
    .flags_o (tbl_flags)
  );

  pdeb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (wk_q.fail_streak),
    .divisor_i  (rint_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    wk_d      = wk_q;
    act_d     = act_q;
    clr_d     = clr_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    tbl_wr    = '0;
    case (state_q)
      ST_IDLE: begin
        act_d = ACT_NONE;
        clr_d = 1'b0;
        if (in_i.valid) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (dom_ok_q) begin
          wk_d.reinit_total = tbl_entry.reinit_total;
          if (!op_q) begin
            wk_d.fail_total  = sat_inc(tbl_entry.fail_total);
            wk_d.fail_streak = sat_inc(tbl_entry.fail_streak);
            wk_d.succ_run    = '0;
          end else begin
            wk_d.fail_total  = tbl_entry.fail_total;
            wk_d.fail_streak = '0;
            wk_d.succ_run    = sat_inc(tbl_entry.succ_run);
          end
          state_d = ST_EVAL;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_EVAL: begin
        state_d = ST_WRITE;
        if (!op_q) begin
          if (wk_q.fail_streak >= thr_q) begin
            act_d = ACT_FAULT;
          end else if (rint_q != '0) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end else if (tbl_flags[idx] && (wk_q.succ_run >= rec_q)) begin
          clr_d = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            act_d             = ACT_REINIT;
            wk_d.reinit_total = sat_inc(wk_q.reinit_total);
          end
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load        = 1'b1;
          tbl_wr.en       = dom_ok_q;
          tbl_wr.flag_set = (act_q == ACT_FAULT);
          tbl_wr.flag_clr = clr_q;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Fault flags as they stand after this item's update.
  always_comb begin
    flags_new = tbl_flags;
    if (act_q == ACT_FAULT) begin
      flags_new[idx] = 1'b1;
    end else if (clr_q) begin
      flags_new[idx] = 1'b0;
    end
  end

  assign flags_ext = {{MASK_W{1'b0}}, flags_new};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wk_q  <= wk_d;
    act_q <= act_d;
    clr_q <= clr_d;
    if (in_beat) begin
      op_q     <= in_i.operation;
      dom_q    <= in_i.domain;
      dom_ok_q <= ({1'b0, in_i.domain} < (DOM_W + 1)'(DOMAIN_COUNT));
    end
    if (out_load) begin
      out_act_q  <= act_q;
      out_flt_q  <= dom_ok_q && flags_new[idx];
      out_mask_q <= flags_ext[MASK_W-1:0];
      out_tot_q  <= dom_ok_q ? wk_q.fail_total   : '0;
      out_str_q  <= dom_ok_q ? wk_q.fail_streak  : '0;
      out_rei_q  <= dom_ok_q ? wk_q.reinit_total : '0;
    end
  end

  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.action          = out_act_q;
  assign out_o.domain_faulted  = out_flt_q;
  assign out_o.fault_mask      = out_mask_q;
  assign out_o.total_failures  = out_tot_q;
  assign out_o.streak_failures = out_str_q;
  assign out_o.reinit_count    = out_rei_q;

  // The remainder unit only runs for failures on a real domain.
  `PDEB_ASSERT_IMP(a_div_fail_only, state_q == ST_DIV, !op_q && dom_ok_q)
  // A re-init is only advised while the streak is below the fault threshold.
  `PDEB_ASSERT_IMP(a_reinit_below_thr, (state_q == ST_WRITE) && (act_q == ACT_REINIT), wk_q.fail_streak < thr_q)
  // A fault answer always shows the domain as faulted.
  `PDEB_ASSERT_NXT(a_fault_shown, out_load, (out_o.action != ACT_FAULT) || out_o.domain_faulted)
  // A pending result is never overwritten while the receiver stalls.
  `PDEB_ASSERT_NXT(a_wait_on_stall, (state_q == ST_WRITE) && out_valid_q && !out_o.ready, state_q == ST_WRITE)

endmodule

// ===== design/pdeb_div.sv =====
// ---------------------------------------------------------------------------
// pdeb_div
// Serial restoring remainder unit: one quotient bit per cycle, 32 steps.
// ---------------------------------------------------------------------------
module pdeb_div import pdeb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [CNT_W-1:0] rem_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  dsr_q, dsr_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  assign trial = {rem_q, dvd_q[CNT_W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // Keep the trial value where it is below the divisor.
      rem_d  = diff[CNT_W] ? trial[CNT_W-1:0] : diff[CNT_W-1:0];
      dvd_d  = {dvd_q[CNT_W-2:0], 1'b0};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/pdeb_table.sv =====
// ---------------------------------------------------------------------------
// pdeb_table
// Per-domain counter storage and the latched fault flags, cleared at reset.
// ---------------------------------------------------------------------------
module pdeb_table import pdeb_pkg::*; #(
  parameter  int unsigned DOMAIN_COUNT = DEF_DOMAIN_COUNT,
  localparam int unsigned IDX_W        = (DOMAIN_COUNT > 1) ? $clog2(DOMAIN_COUNT) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [IDX_W-1:0]        idx_i,
  input  pdeb_wr_t                wr_i,
  input  pdeb_entry_t             entry_i,
  output pdeb_entry_t             entry_o,
  output logic [DOMAIN_COUNT-1:0] flags_o
);

  pdeb_entry_t             entries_q [DOMAIN_COUNT];
  logic [DOMAIN_COUNT-1:0] flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DOMAIN_COUNT; i++) begin
        entries_q[i] <= '0;
      end
      flags_q <= '0;
    end else if (wr_i.en) begin
      entries_q[idx_i] <= entry_i;
      if (wr_i.flag_set) begin
        flags_q[idx_i] <= 1'b1;
      end else if (wr_i.flag_clr) begin
        flags_q[idx_i] <= 1'b0;
      end
    end
  end

  assign entry_o = entries_q[idx_i];
  assign flags_o = flags_q;

endmodule
